>>> sv/threshold_array_halftone_packer_unit_defines.svh
// ----------------------------------------------------------------------------
// Halftone packer assertion macros
// Shared concurrent assertion forms for the halftone packer checkers.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_ARRAY_HALFTONE_PACKER_UNIT_DEFINES_SVH
`define THRESHOLD_ARRAY_HALFTONE_PACKER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define THAP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define THAP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/thap_pkg.sv
// ----------------------------------------------------------------------------
// Halftone packer package
// Types, codes and fixed widths shared by the halftone packer modules.
// ----------------------------------------------------------------------------
package thap_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TILE_WIDTH  = 3'd0,
        REG_TILE_HEIGHT = 3'd1,
        REG_X_PHASE     = 3'd2,
        REG_RATIO       = 3'd3,
        REG_DROP_SIZE   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] tile_width;
        logic [7:0] tile_height;
        logic [6:0] x_phase;
        logic [8:0] ratio;
        logic [1:0] drop_size;
    } cfg_t;

    localparam logic [7:0] TILE_WIDTH_RESET  = 8'd128;
    localparam logic [7:0] TILE_HEIGHT_RESET = 8'd128;
    localparam logic [6:0] X_PHASE_RESET     = 7'd0;
    localparam logic [8:0] RATIO_FULL        = 9'd257;
    localparam logic [1:0] DROP_SIZE_RESET   = 2'd0;

    // Drop size selectors and the codes they produce
    localparam logic [1:0] DROP_SMALL  = 2'd1;
    localparam logic [1:0] DROP_MEDIUM = 2'd2;
    localparam logic [1:0] CODE_SMALL  = 2'b01;
    localparam logic [1:0] CODE_MEDIUM = 2'b10;
    localparam logic [1:0] CODE_LARGE  = 2'b11;

    // Input mode
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SCREEN = 1'b1;

    // Stream payload
    localparam int ADDR_W      = 14;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int THR_W       = 16;
    localparam int PIXEL_W     = 8;
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;

    // Front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic hit;
        logic soi;
        logic eol;
    } entry_t;

endpackage

>>> sv/thap_front.sv
// ----------------------------------------------------------------------------
// Halftone packer front end
// Accepts items, tracks tile phase, writes and reads the threshold store and
// classifies each pixel as hit or miss for the packing back end.
// ----------------------------------------------------------------------------
module thap_front #(
    parameter int MAX_TILE_WIDTH  = 128,
    parameter int MAX_TILE_HEIGHT = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: load_index[13:0], threshold_value[29:14], pixel[37:30], zero pad
    input  logic [thap_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    // s_tuser: mode[0], start_of_image[1]
    input  logic [thap_pkg::S_TUSER_W-1:0]  s_tuser,
    input  thap_pkg::cfg_t                  cfg,
    input  logic [thap_pkg::Q_CNT_W-1:0]    q_count,
    output logic                            push_valid,
    output thap_pkg::entry_t                push_entry
);
    import thap_pkg::*;

    localparam int SZ_W   = 9;
    localparam int FULL_W = 2 * SZ_W;
    localparam int COL_W  = (MAX_TILE_WIDTH > 1) ? $clog2(MAX_TILE_WIDTH) : 1;
    localparam int ROW_W  = (MAX_TILE_HEIGHT > 1) ? $clog2(MAX_TILE_HEIGHT) : 1;
    localparam logic [SZ_W-1:0] MAX_TW = SZ_W'(MAX_TILE_WIDTH);
    localparam logic [SZ_W-1:0] MAX_TH = SZ_W'(MAX_TILE_HEIGHT);

    function automatic logic [SZ_W-1:0] eff_size(input logic [7:0] v,
                                                 input logic [SZ_W-1:0] max_v);
        logic [SZ_W-1:0] ext;
        ext = SZ_W'(v);
        if (v == 8'd0)
            return SZ_W'(1);
        else if (ext > max_v)
            return max_v;
        else
            return ext;
    endfunction

    // Phase state
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // Stage A: address and scaled pixel
    logic              a_valid_reg;
    logic              a_load_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [THR_W-1:0]  a_wdata_reg;
    logic [THR_W-1:0]  a_scaled_reg;
    logic              a_gate_reg;
    logic              a_soi_reg;
    logic              a_eol_reg;

    // Stage B: threshold read back
    logic              b_valid_reg;
    logic [THR_W-1:0]  b_scaled_reg;
    logic              b_gate_reg;
    logic              b_soi_reg;
    logic              b_eol_reg;

    logic [THR_W-1:0]  thr_store_reg [STORE_DEPTH];
    logic [THR_W-1:0]  thr_rd_reg;

    logic               accept;
    logic               in_mode;
    logic               in_soi;
    logic [ADDR_W-1:0]  in_addr;
    logic [THR_W-1:0]   in_thr;
    logic [PIXEL_W-1:0] in_pixel;

    logic [SZ_W-1:0]    tw_eff, th_eff;
    logic [SZ_W-1:0]    start_col_w, row_inc, col_inc;
    logic [COL_W-1:0]   start_col, cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [FULL_W-1:0]  addr_full;
    logic [8:0]         ratio_sat;
    logic [16:0]        scaled_full;
    logic [THR_W-1:0]   scaled;
    logic [Q_CNT_W:0]   credit;

    // Unpack the input item
    assign in_mode  = s_tuser[0];
    assign in_soi   = s_tuser[1];
    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_thr   = s_tdata[ADDR_W+THR_W-1:ADDR_W];
    assign in_pixel = s_tdata[ADDR_W+THR_W+PIXEL_W-1:ADDR_W+THR_W];

    // Hold off input when the queue could not absorb every pixel in flight
    assign credit   = (Q_CNT_W+1)'(q_count)
                    + (Q_CNT_W+1)'(a_valid_reg && !a_load_reg)
                    + (Q_CNT_W+1)'(b_valid_reg);
    assign s_tready = credit < (Q_CNT_W+1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // Phase, address and scaling for the current item
    always_comb
    begin
        tw_eff      = eff_size(cfg.tile_width, MAX_TW);
        th_eff      = eff_size(cfg.tile_height, MAX_TH);
        start_col_w = (SZ_W'(cfg.x_phase) >= tw_eff) ? '0 : SZ_W'(cfg.x_phase);
        start_col   = start_col_w[COL_W-1:0];

        if (in_soi)
            cur_row = '0;
        else if (SZ_W'(row_reg) >= th_eff)
            cur_row = '0;
        else
            cur_row = row_reg;

        if (in_soi)
            cur_col = start_col;
        else if (SZ_W'(col_reg) >= tw_eff)
            cur_col = '0;
        else
            cur_col = col_reg;

        row_inc = SZ_W'(cur_row) + SZ_W'(1);
        col_inc = SZ_W'(cur_col) + SZ_W'(1);

        if (s_tlast)
        begin
            row_next = (row_inc >= th_eff) ? '0 : row_inc[ROW_W-1:0];
            col_next = start_col;
        end
        else
        begin
            row_next = cur_row;
            col_next = (col_inc >= tw_eff) ? '0 : col_inc[COL_W-1:0];
        end

        addr_full   = FULL_W'(cur_row) * FULL_W'(tw_eff) + FULL_W'(cur_col);
        ratio_sat   = (cfg.ratio > RATIO_FULL) ? RATIO_FULL : cfg.ratio;
        scaled_full = 17'(in_pixel) * 17'(ratio_sat);
        scaled      = scaled_full[THR_W-1:0];
    end

    // Advance phase on each accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept && in_mode == MODE_SCREEN)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Stage A and B valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg && !a_load_reg;
        end
    end

    // Stage A and B payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_load_reg   <= (in_mode == MODE_LOAD);
            a_addr_reg   <= (in_mode == MODE_LOAD) ? in_addr : addr_full[ADDR_W-1:0];
            a_wdata_reg  <= in_thr;
            a_scaled_reg <= scaled;
            a_gate_reg   <= (in_pixel != '0) && (scaled != '0);
            a_soi_reg    <= in_soi;
            a_eol_reg    <= s_tlast;
        end
        b_scaled_reg <= a_scaled_reg;
        b_gate_reg   <= a_gate_reg;
        b_soi_reg    <= a_soi_reg;
        b_eol_reg    <= a_eol_reg;
    end

    // Threshold store: one write or one registered read per cycle, in order
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            if (a_load_reg)
                thr_store_reg[a_addr_reg] <= a_wdata_reg;
            else
                thr_rd_reg <= thr_store_reg[a_addr_reg];
        end
    end

    // Classify the pixel and hand it to the queue
    assign push_valid     = b_valid_reg;
    assign push_entry.hit = b_gate_reg && (b_scaled_reg >= thr_rd_reg);
    assign push_entry.soi = b_soi_reg;
    assign push_entry.eol = b_eol_reg;

endmodule

>>> sv/thap_queue.sv
// ----------------------------------------------------------------------------
// Halftone packer queue
// Short in-order queue of classified pixels between front and back end.
// ----------------------------------------------------------------------------
module thap_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push_valid,
    input  thap_pkg::entry_t              push_entry,
    input  logic                          pop,
    output thap_pkg::entry_t              pop_entry,
    output logic [thap_pkg::Q_CNT_W-1:0]  count
);
    import thap_pkg::*;

    entry_t               slot_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign pop_entry = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Track occupancy; the front end never pushes into a full queue
    always_comb
    begin
        count_next = count_reg + Q_CNT_W'(push_valid) - Q_CNT_W'(pop);
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push_valid)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> sv/thap_back.sv
// ----------------------------------------------------------------------------
// Halftone packer back end
// Packs four drop codes per byte, flushes at line end, and holds the output
// byte in a register until the downstream transfer completes.
// ----------------------------------------------------------------------------
module thap_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      drop_size,
    input  logic [thap_pkg::Q_CNT_W-1:0]    q_count,
    input  thap_pkg::entry_t                q_entry,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: packed_byte[7:0]
    output logic [thap_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import thap_pkg::*;

    logic [1:0]           lane_reg;
    logic [M_TDATA_W-1:0] acc_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    logic [1:0]           lane_base;
    logic [M_TDATA_W-1:0] acc_base, acc_new, lane_bits;
    logic [1:0]           code;
    logic [2:0]           shamt;
    logic                 emit;
    logic                 out_free;

    // Pick the drop code and place it in the current lane
    always_comb
    begin
        lane_base = q_entry.soi ? 2'd0 : lane_reg;
        acc_base  = q_entry.soi ? '0 : acc_reg;
        unique case (drop_size)
            DROP_SMALL:  code = CODE_SMALL;
            DROP_MEDIUM: code = CODE_MEDIUM;
            default:     code = CODE_LARGE;
        endcase
        shamt     = {~lane_base, 1'b0};
        lane_bits = M_TDATA_W'(code) << shamt;
        acc_new   = acc_base | (q_entry.hit ? lane_bits : '0);
        emit      = (lane_base == 2'd3) || q_entry.eol;
    end

    // Take an entry unless it must emit while the output is still occupied
    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = (q_count != '0) && (!emit || out_free);

    // Lane, accumulator and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg     <= 2'd0;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (pop && emit)
        begin
            lane_reg     <= 2'd0;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b1;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (pop)
            begin
                lane_reg <= lane_base + 2'd1;
                acc_reg  <= acc_new;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            m_tdata_reg <= acc_new;
            m_tlast_reg <= q_entry.eol;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> sv/threshold_array_halftone_packer_unit.sv
// ----------------------------------------------------------------------------
// Threshold array halftone packer
// Ordered-dither screen of 8-bit pixels against a tiled 16-bit threshold
// matrix, packing four 2-bit drop codes into each output byte.
// ----------------------------------------------------------------------------
// One item is accepted per clock, loads and pixels alike, as long as the
// output side keeps up; a load produces no byte. On its way to the output
// register a pixel passes stage A, which registers phase, address and the
// pixel scaling multiply, stage B, which does the registered read of the
// threshold store, and the four-entry queue, after which the packed byte is
// loaded into the output register. Input is held off only when the queue
// could not take every pixel already in flight, so a stalled output backs
// up through the queue. Loads and pixels use the single store port in
// arrival order, so a pixel sees every load accepted before it. The store
// is not cleared at reset; read only entries that were loaded. Configuration
// writes take effect at once and belong between images.
module threshold_array_halftone_packer_unit #(
    parameter int MAX_TILE_WIDTH  = 128,
    parameter int MAX_TILE_HEIGHT = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [thap_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [thap_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: load_index[13:0], threshold_value[29:14], pixel[37:30], zero pad
    input  logic [thap_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tlast: end_of_line
    input  logic                              s_tlast,
    // s_tuser: mode[0], start_of_image[1]
    input  logic [thap_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: packed_byte[7:0]
    output logic [thap_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tlast: line_last
    output logic                              m_tlast
);
    import thap_pkg::*;

    cfg_t               cfg_reg;
    logic               push_valid;
    entry_t             push_entry;
    entry_t             q_entry;
    logic               pop;
    logic [Q_CNT_W-1:0] q_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width  <= TILE_WIDTH_RESET;
            cfg_reg.tile_height <= TILE_HEIGHT_RESET;
            cfg_reg.x_phase     <= X_PHASE_RESET;
            cfg_reg.ratio       <= RATIO_FULL;
            cfg_reg.drop_size   <= DROP_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TILE_WIDTH:  cfg_reg.tile_width  <= cfg_data[7:0];
                REG_TILE_HEIGHT: cfg_reg.tile_height <= cfg_data[7:0];
                REG_X_PHASE:     cfg_reg.x_phase     <= cfg_data[6:0];
                REG_RATIO:       cfg_reg.ratio       <= cfg_data[8:0];
                REG_DROP_SIZE:   cfg_reg.drop_size   <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    thap_front #(
        .MAX_TILE_WIDTH  (MAX_TILE_WIDTH),
        .MAX_TILE_HEIGHT (MAX_TILE_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    thap_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (q_entry),
        .count      (q_count)
    );

    thap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .drop_size (cfg_reg.drop_size),
        .q_count   (q_count),
        .q_entry   (q_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> sv/thap_checker.sv
// ----------------------------------------------------------------------------
// Halftone packer port checker
// Port-level checks of reset, output stall behavior and minimum latency.
// ----------------------------------------------------------------------------
`include "threshold_array_halftone_packer_unit_defines.svh"

module thap_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [thap_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);
    // A stalled byte stays offered with the same payload
    property p_stall_hold;
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast);
    endproperty

    // No byte is offered once reset has been sampled asserted
    `THAP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "output valid during reset")

    // Hold a stalled byte unchanged
    `THAP_ASSERT(a_stall_hold, p_stall_hold, "stalled output byte changed")

    // A byte needs the full pipeline behind it after reset release
    `THAP_ASSERT(a_min_latency, $rose(m_tvalid) |-> $past(rst_n, 4), "output byte too early")

endmodule

bind threshold_array_halftone_packer_unit thap_checker u_thap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> test/threshold_array_halftone_packer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halftone packer testbench
// Streams threshold loads and pixel lines into the packer with random gaps on
// the input and random stalls on the output, and predicts every packed byte
// with its own copy of the matrix, phases and lane state. Configuration
// changes between phases while the block is idle. One long output stall
// backs the pipe up into the input.
// ----------------------------------------------------------------------------
module threshold_array_halftone_packer_unit_tb;

    import thap_pkg::*;

    localparam int MAX_TW      = 128;
    localparam int MAX_TH      = 128;
    localparam int ITEM_GOAL   = 650;
    localparam int CALM_ITEMS  = 100;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic               mode;
        logic [ADDR_W-1:0]  load_index;
        logic [THR_W-1:0]   threshold_value;
        logic [PIXEL_W-1:0] pixel;
        logic               start_of_image;
        logic               end_of_line;
    } screen_item_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       line_last;
    } screen_out_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    threshold_array_halftone_packer_unit #(
        .MAX_TILE_WIDTH  (MAX_TW),
        .MAX_TILE_HEIGHT (MAX_TH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pending transfers and expected bytes
    screen_item_t item_queue[$];
    screen_out_t  byte_expect[$];

    // Mirrored configuration
    logic [7:0] tile_w_reg  = TILE_WIDTH_RESET;
    logic [7:0] tile_h_reg  = TILE_HEIGHT_RESET;
    logic [6:0] x_phase_reg = X_PHASE_RESET;
    logic [8:0] ratio_reg   = RATIO_FULL;
    logic [1:0] drop_reg    = DROP_SIZE_RESET;

    // Mirrored screen state
    logic [THR_W-1:0] thr_shadow [STORE_DEPTH];
    logic [6:0]       row_ph   = '0;
    logic [6:0]       col_ph   = '0;
    logic [1:0]       lane_idx = '0;
    logic [7:0]       acc_byte = '0;

    // Matrix entries that have been loaded, tracked at generation time
    bit loaded [STORE_DEPTH];

    int  fail_cnt   = 0;
    int  items_made = 0;
    int  cycle_cnt  = 0;
    int  gap_left   = 0;
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_req   = 1'b0;
    bit  idle_on    = 1'b1;
    bit  steady     = 1'b0;

    screen_item_t cur_item;
    screen_out_t  exp_byte;

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned mx);
        if (v == 0)
            return 1;
        return (v > mx) ? mx : v;
    endfunction

    function automatic logic [6:0] line_start(input int unsigned tw);
        return (x_phase_reg >= tw) ? 7'd0 : x_phase_reg;
    endfunction

    // Advance the mirrored block by one accepted transfer
    task automatic screen_transfer(input screen_item_t it);
        int unsigned tw;
        int unsigned th;
        int unsigned rr;
        int unsigned scaled;
        int unsigned addr;
        logic [1:0]  code;
        screen_out_t res;
        if (it.mode == MODE_LOAD)
        begin
            thr_shadow[it.load_index] = it.threshold_value;
            return;
        end
        tw = eff_size(tile_w_reg, MAX_TW);
        th = eff_size(tile_h_reg, MAX_TH);
        if (it.start_of_image)
        begin
            row_ph   = '0;
            col_ph   = line_start(tw);
            lane_idx = '0;
            acc_byte = '0;
        end
        if (row_ph >= th)
            row_ph = '0;
        if (col_ph >= tw)
            col_ph = '0;
        rr     = (ratio_reg > RATIO_FULL) ? RATIO_FULL : ratio_reg;
        scaled = it.pixel * rr;
        if (it.pixel != 0 && scaled != 0)
        begin
            addr = (row_ph * tw + col_ph) & (STORE_DEPTH - 1);
            if (scaled >= thr_shadow[addr])
            begin
                code = (drop_reg == DROP_SMALL)  ? CODE_SMALL :
                       (drop_reg == DROP_MEDIUM) ? CODE_MEDIUM : CODE_LARGE;
                acc_byte = acc_byte | (8'(code) << (6 - 2 * lane_idx));
            end
        end
        if (lane_idx == 2'd3 || it.end_of_line)
        begin
            res.packed_byte = acc_byte;
            res.line_last   = it.end_of_line;
            byte_expect.push_back(res);
            acc_byte = '0;
            lane_idx = '0;
        end
        else
            lane_idx = lane_idx + 2'd1;
        if (it.end_of_line)
        begin
            row_ph = (int'(row_ph) + 1 >= th) ? 7'd0 : row_ph + 7'd1;
            col_ph = line_start(tw);
        end
        else
            col_ph = (int'(col_ph) + 1 >= tw) ? 7'd0 : col_ph + 7'd1;
    endtask

    // Input driver: present queued transfers, insert random gaps
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                screen_transfer(cur_item);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (item_queue.size() != 0)
                begin
                    cur_item = item_queue.pop_front();
                    s_tdata  <= {2'b00, cur_item.pixel, cur_item.threshold_value,
                                 cur_item.load_index};
                    s_tlast  <= cur_item.end_of_line;
                    s_tuser  <= {cur_item.start_of_image, cur_item.mode};
                    s_tvalid <= 1'b1;
                    if (idle_on && !steady && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 3);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long output hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Output monitor: check each byte transfer, drive random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (byte_expect.size() == 0)
                begin
                    $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                             $time, m_tdata, m_tlast);
                    fail_cnt++;
                end
                else
                begin
                    exp_byte = byte_expect.pop_front();
                    if (m_tdata !== exp_byte.packed_byte)
                    begin
                        $display("%0t: packed_byte mismatch: expected %02h, actual %02h",
                                 $time, exp_byte.packed_byte, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tlast !== exp_byte.line_last)
                    begin
                        $display("%0t: line_last mismatch: expected %0b, actual %0b",
                                 $time, exp_byte.line_last, m_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && !steady && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("threshold_array_halftone_packer_unit_tb failed");
            $finish;
        end
    end

    function automatic logic [15:0] rand_thr();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_load(input int unsigned addr, input logic [15:0] val);
        screen_item_t it;
        it.mode            = MODE_LOAD;
        it.load_index      = ADDR_W'(addr);
        it.threshold_value = val;
        it.pixel           = 8'($urandom_range(0, 255));
        it.start_of_image  = ($urandom_range(0, 7) == 0);
        it.end_of_line     = ($urandom_range(0, 7) == 0);
        loaded[it.load_index] = 1'b1;
        item_queue.push_back(it);
        items_made++;
    endtask

    task automatic push_pixel(input logic [7:0] pix, input bit soi, input bit eol);
        screen_item_t it;
        it.mode            = MODE_SCREEN;
        it.load_index      = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
        it.threshold_value = 16'($urandom_range(0, 65535));
        it.pixel           = pix;
        it.start_of_image  = soi;
        it.end_of_line     = eol;
        item_queue.push_back(it);
        items_made++;
    endtask

    // Load every matrix entry the current tile can read
    task automatic fill_tile();
        int unsigned span;
        span = eff_size(tile_w_reg, MAX_TW) * eff_size(tile_h_reg, MAX_TH);
        for (int unsigned i = 0; i < span; i++)
            if (!loaded[i])
                push_load(i, rand_thr());
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [8:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_TILE_WIDTH:  tile_w_reg  = val[7:0];
            REG_TILE_HEIGHT: tile_h_reg  = val[7:0];
            REG_X_PHASE:     x_phase_reg = val[6:0];
            REG_RATIO:       ratio_reg   = val;
            REG_DROP_SIZE:   drop_reg    = val[1:0];
            default: ;
        endcase
    endtask

    // Hold until every transfer is in and every byte is out, then let it settle
    task automatic wait_drained();
        while (item_queue.size() != 0 || s_tvalid || byte_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    logic [15:0] corner_thr [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                    16'h7FFF, 16'hFF00, 16'h00FF, 16'hFFFE};

    // Stimulus
    initial
    begin
        int          phase;
        int          n_lines;
        int          len;
        int unsigned tw_new;
        int unsigned th_new;
        int unsigned sel;
        logic [8:0]  ratio_new;
        bit          first;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Zero pixels under the reset tile: the gate makes every pixel a miss, line ends on lane 3
        push_pixel(8'd0, 1'b1, 1'b0);
        push_pixel(8'd0, 1'b0, 1'b0);
        push_pixel(8'd0, 1'b0, 1'b0);
        push_pixel(8'd0, 1'b0, 1'b1);
        wait_drained();

        // Small tile with corner thresholds, every register written
        write_reg(REG_TILE_WIDTH, 9'd4);
        write_reg(REG_TILE_HEIGHT, 9'd2);
        write_reg(REG_X_PHASE, 9'd1);
        write_reg(REG_RATIO, 9'(RATIO_FULL));
        write_reg(REG_DROP_SIZE, 9'(DROP_SMALL));
        for (int i = 0; i < 8; i++)
            push_load(i, corner_thr[i]);
        push_load(STORE_DEPTH - 1, 16'hFFFF);
        push_pixel(8'd255, 1'b1, 1'b0);
        push_pixel(8'd1, 1'b0, 1'b0);
        push_pixel(8'd128, 1'b0, 1'b0);
        push_pixel(8'd0, 1'b0, 1'b0);
        push_pixel(8'd255, 1'b0, 1'b1);
        push_pixel(8'd200, 1'b0, 1'b0);
        push_pixel(8'd7, 1'b0, 1'b0);
        push_pixel(8'd255, 1'b0, 1'b1);

        // Random phases
        phase = 0;
        while (items_made < ITEM_GOAL)
        begin
            wait_drained();
            steady  = (items_made >= ITEM_GOAL - CALM_ITEMS);
            idle_on = ($urandom_range(0, 3) != 0);

            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                tw_new = ($urandom_range(0, 1) != 0) ? 128 : $urandom_range(129, 255);
                th_new = $urandom_range(0, 1);
            end
            else if (sel == 1)
            begin
                tw_new = $urandom_range(0, 1);
                th_new = ($urandom_range(0, 1) != 0) ? 128 : $urandom_range(129, 255);
            end
            else
            begin
                tw_new = $urandom_range(0, 12);
                th_new = $urandom_range(0, 6);
            end
            case ($urandom_range(0, 7))
                0: ratio_new = 9'd0;
                1: ratio_new = 9'(RATIO_FULL);
                2: ratio_new = 9'd511;
                3: ratio_new = 9'($urandom_range(258, 511));
                default: ratio_new = 9'($urandom_range(1, 256));
            endcase

            if ($urandom_range(0, 9) < 7)
                write_reg(REG_TILE_WIDTH, 9'(tw_new));
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_TILE_HEIGHT, 9'(th_new));
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_reg(REG_X_PHASE, 9'($urandom_range(0, 127)));
                else
                    write_reg(REG_X_PHASE,
                              9'($urandom_range(0, eff_size(tile_w_reg, MAX_TW) - 1)));
            end
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_RATIO, ratio_new);
            if ($urandom_range(0, 9) < 7)
                write_reg(REG_DROP_SIZE, 9'($urandom_range(0, 3)));

            // Stall the output long enough for the input to back up
            if (phase == 2)
            begin
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end

            fill_tile();
            n_lines = (phase == 2) ? 6 : $urandom_range(2, 6);
            first   = ($urandom_range(0, 9) < 7);
            for (int ln = 0; ln < n_lines; ln++)
            begin
                len = (phase == 2) ? 12 : $urandom_range(1, 14);
                for (int p = 0; p < len; p++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        if ($urandom_range(0, 1) != 0)
                            push_load($urandom_range(0, STORE_DEPTH - 1), rand_thr());
                        else
                            push_load($urandom_range(0, eff_size(tile_w_reg, MAX_TW) *
                                                        eff_size(tile_h_reg, MAX_TH) - 1),
                                      rand_thr());
                    end
                    push_pixel(rand_pixel(), first || ($urandom_range(0, 39) == 0),
                               (p == len - 1) && ($urandom_range(0, 9) != 0));
                    first = 1'b0;
                end
            end
            phase++;
        end

        wait_drained();
        if (fail_cnt == 0)
            $display("threshold_array_halftone_packer_unit_tb passed");
        else
            $display("threshold_array_halftone_packer_unit_tb failed");
        $finish;
    end

endmodule
